>>> src/hwsa_pkg.sv
// Package for the homography warp source address block.
// Holds the shared widths, defaults and the control struct; no dependencies.
`default_nettype none

package hwsa_pkg;

    // Fixed field widths.
    localparam int COEF_BITS = 32;
    localparam int SIZE_BITS = 13;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_INDEX_BITS = 3;

    // Defaults for the top-level parameters.
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_COEF_FRAC_BITS = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_M00_M01 = 3'd0,
        REG_M02_M10 = 3'd1,
        REG_M11_M12 = 3'd2,
        REG_M20_M21 = 3'd3,
        REG_M22     = 3'd4,
        REG_WIDTH   = 3'd5,
        REG_HEIGHT  = 3'd6
    } cfg_reg_t;

    // Reset sizes of the source image.
    localparam logic [SIZE_BITS-1:0] RST_WIDTH = 13'd600;
    localparam logic [SIZE_BITS-1:0] RST_HEIGHT = 13'd400;

    // Control that travels with each word down the pipeline.
    typedef struct packed {
        logic vld;
        logic ok;
    } hwsa_ctl_t;

endpackage : hwsa_pkg

`default_nettype wire

>>> src/hwsa_if.sv
// Channel interfaces of the homography warp source address block.
// Depends on nothing; the coordinate width comes in as a parameter.
`default_nettype none

interface hwsa_in_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_col;
    logic [COORD_BITS-1:0] out_row;

    modport source (output valid, output out_col, output out_row, input ready);
    modport sink (input valid, input out_col, input out_row, output ready);
endinterface : hwsa_in_if

interface hwsa_out_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] src_col;
    logic [COORD_BITS-1:0] src_row;
    logic                  src_valid;

    modport source (output valid, output src_col, output src_row, output src_valid,
                    input ready);
    modport sink (input valid, input src_col, input src_row, input src_valid,
                  output ready);
endinterface : hwsa_out_if

`default_nettype wire

>>> src/hwsa_mac.sv
// Front end: the 3x3 matrix product, magnitudes and range screening.
// Depends on hwsa_pkg.
`default_nettype none

module hwsa_mac
    import hwsa_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    localparam int PW = COEF_BITS + COORD_BITS + 1,
    localparam int SW = PW + 2,
    localparam int MAG = SW - 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic [COORD_BITS-1:0] col,
    input  wire logic [COORD_BITS-1:0] row,
    input  wire logic [COEF_BITS-1:0]  m00,
    input  wire logic [COEF_BITS-1:0]  m01,
    input  wire logic [COEF_BITS-1:0]  m02,
    input  wire logic [COEF_BITS-1:0]  m10,
    input  wire logic [COEF_BITS-1:0]  m11,
    input  wire logic [COEF_BITS-1:0]  m12,
    input  wire logic [COEF_BITS-1:0]  m20,
    input  wire logic [COEF_BITS-1:0]  m21,
    input  wire logic [COEF_BITS-1:0]  m22,
    output hwsa_ctl_t                  ctl,
    output logic [MAG-1:0]             abs_x,
    output logic [MAG-1:0]             abs_y,
    output logic [MAG-1:0]             abs_w
);

    logic signed [COORD_BITS:0] c_s;
    logic signed [COORD_BITS:0] r_s;

    logic signed [PW-1:0] p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [COEF_BITS-1:0] k02_reg, k12_reg, k22_reg;
    logic signed [SW-1:0] x_reg, y_reg, w_reg;
    logic [MAG-1:0] ax_reg, ay_reg, aw_reg;
    logic sx_reg, sy_reg, sw_reg, zx_reg, zy_reg, zw_reg;
    logic [MAG-1:0] ax4_reg, ay4_reg, aw4_reg;
    logic ok4_reg;
    logic [3:0] vld_reg;
    logic [MAG+COORD_BITS-1:0] lim_w;
    logic ok_next;

    assign c_s = $signed({1'b0, col});
    assign r_s = $signed({1'b0, row});

    // Valid bits of the four front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    // Stage one: the six coordinate products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= PW'($signed(m00) * c_s);
            p01_reg <= PW'($signed(m01) * r_s);
            p10_reg <= PW'($signed(m10) * c_s);
            p11_reg <= PW'($signed(m11) * r_s);
            p20_reg <= PW'($signed(m20) * c_s);
            p21_reg <= PW'($signed(m21) * r_s);
            k02_reg <= $signed(m02);
            k12_reg <= $signed(m12);
            k22_reg <= $signed(m22);
        end
    end

    // Stage two: the homogeneous sums x, y and w.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= SW'(p00_reg) + SW'(p01_reg) + SW'(k02_reg);
            y_reg <= SW'(p10_reg) + SW'(p11_reg) + SW'(k12_reg);
            w_reg <= SW'(p20_reg) + SW'(p21_reg) + SW'(k22_reg);
        end
    end

    // Stage three: signs, zero flags and magnitudes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= x_reg[SW-1];
            sy_reg <= y_reg[SW-1];
            sw_reg <= w_reg[SW-1];
            zx_reg <= (x_reg == '0);
            zy_reg <= (y_reg == '0);
            zw_reg <= (w_reg == '0);
            ax_reg <= MAG'(x_reg[SW-1] ? -x_reg : x_reg);
            ay_reg <= MAG'(y_reg[SW-1] ? -y_reg : y_reg);
            aw_reg <= MAG'(w_reg[SW-1] ? -w_reg : w_reg);
        end
    end

    // Stage four: a zero w, a negative quotient or one past the coordinate range is out.
    assign lim_w = {aw_reg, {COORD_BITS{1'b0}}};
    assign ok_next = !zw_reg
                     && (zx_reg || (sx_reg == sw_reg))
                     && (zy_reg || (sy_reg == sw_reg))
                     && ((MAG+COORD_BITS)'(ax_reg) < lim_w)
                     && ((MAG+COORD_BITS)'(ay_reg) < lim_w);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax4_reg <= ax_reg;
            ay4_reg <= ay_reg;
            aw4_reg <= aw_reg;
            ok4_reg <= ok_next;
        end
    end

    assign ctl.vld = vld_reg[3];
    assign ctl.ok = ok4_reg;
    assign abs_x = ax4_reg;
    assign abs_y = ay4_reg;
    assign abs_w = aw4_reg;

endmodule : hwsa_mac

`default_nettype wire

>>> src/hwsa_div_cell.sv
// One cell of the divider chain: settles one quotient bit of x/w and y/w.
// Depends on hwsa_pkg.
`default_nettype none

module hwsa_div_cell
    import hwsa_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int BIT = 0,
    localparam int MAG = COEF_BITS + COORD_BITS + 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire hwsa_ctl_t             ctl_i,
    input  wire logic [MAG-1:0]        rem_x_i,
    input  wire logic [MAG-1:0]        rem_y_i,
    input  wire logic [MAG-1:0]        den_i,
    input  wire logic [COORD_BITS-1:0] q_x_i,
    input  wire logic [COORD_BITS-1:0] q_y_i,
    output hwsa_ctl_t                  ctl_o,
    output logic [MAG-1:0]             rem_x_o,
    output logic [MAG-1:0]             rem_y_o,
    output logic [MAG-1:0]             den_o,
    output logic [COORD_BITS-1:0]      q_x_o,
    output logic [COORD_BITS-1:0]      q_y_o
);

    localparam int EW = MAG + COORD_BITS;

    logic [EW-1:0] dsh;
    logic [EW-1:0] dx, dy;
    logic          gx, gy;
    hwsa_ctl_t     ctl_reg;
    logic [MAG-1:0] rx_reg, ry_reg, dn_reg;
    logic [COORD_BITS-1:0] qx_reg, qy_reg;
    logic [COORD_BITS-1:0] qx_next, qy_next;

    // Trial subtraction of the shifted divisor from both remainders.
    assign dsh = EW'(den_i) << BIT;
    assign dx = EW'(rem_x_i) - dsh;
    assign dy = EW'(rem_y_i) - dsh;
    assign gx = (EW'(rem_x_i) >= dsh);
    assign gy = (EW'(rem_y_i) >= dsh);

    always_comb
    begin
        qx_next = q_x_i;
        qy_next = q_y_i;
        qx_next[BIT] = gx;
        qy_next[BIT] = gy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= gx ? MAG'(dx) : rem_x_i;
            ry_reg <= gy ? MAG'(dy) : rem_y_i;
            dn_reg <= den_i;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign rem_x_o = rx_reg;
    assign rem_y_o = ry_reg;
    assign den_o = dn_reg;
    assign q_x_o = qx_reg;
    assign q_y_o = qy_reg;

endmodule : hwsa_div_cell

`default_nettype wire

>>> src/homography_warp_source_address_top.sv
// Top level of the homography warp source address block.
// Depends on hwsa_pkg, hwsa_if, hwsa_mac and hwsa_div_cell.
//
// Usage:
//   pix_in carries one output pixel coordinate (out_col, out_row) per word.
//   addr_out returns one word per input word: the ceil source coordinate and
//   src_valid, which is set when w is nonzero and floor and ceil both lie in
//   the image. Invalid words carry zero coordinates.
//   The config port writes one register per cycle with cfg_we high; the
//   index picks the register and unknown indexes are ignored. Write only
//   while the pipeline is empty.
//   The pipeline has four front stages for the matrix product and screening,
//   one divider cell per quotient bit, and the output register. One word is
//   accepted every cycle while the receiver does not stall, as the divider
//   chain is fully pipelined.
//   Reset clears all valid bits and loads the identity matrix and a 600 by
//   400 image. When the receiver stalls, the whole pipeline holds and
//   pix_in.ready drops in the same cycle.
`default_nettype none

module homography_warp_source_address_top
    import hwsa_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    hwsa_in_if.sink                        pix_in,
    hwsa_out_if.source                     addr_out
);

    localparam int MAG = COEF_BITS + COORD_BITS + 2;
    localparam int CMPW = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
    localparam logic [COEF_BITS-1:0] ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    logic [2*COEF_BITS-1:0] m00_m01_reg, m02_m10_reg, m11_m12_reg, m20_m21_reg;
    logic [COEF_BITS-1:0] m22_reg;
    logic [SIZE_BITS-1:0] width_reg, height_reg;

    logic en;
    hwsa_ctl_t ctl [0:COORD_BITS];
    logic [MAG-1:0] rx [0:COORD_BITS];
    logic [MAG-1:0] ry [0:COORD_BITS];
    logic [MAG-1:0] dn [0:COORD_BITS];
    logic [COORD_BITS-1:0] qx [0:COORD_BITS];
    logic [COORD_BITS-1:0] qy [0:COORD_BITS];

    logic [COORD_BITS:0] ceil_x, ceil_y;
    logic fit_next;
    logic out_vld_reg;
    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic sv_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m00_m01_reg <= {ONE, {COEF_BITS{1'b0}}};
            m02_m10_reg <= '0;
            m11_m12_reg <= {ONE, {COEF_BITS{1'b0}}};
            m20_m21_reg <= '0;
            m22_reg <= ONE;
            width_reg <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_M00_M01: m00_m01_reg <= cfg_data;
                REG_M02_M10: m02_m10_reg <= cfg_data;
                REG_M11_M12: m11_m12_reg <= cfg_data;
                REG_M20_M21: m20_m21_reg <= cfg_data;
                REG_M22:     m22_reg <= cfg_data[COEF_BITS-1:0];
                REG_WIDTH:   width_reg <= cfg_data[SIZE_BITS-1:0];
                REG_HEIGHT:  height_reg <= cfg_data[SIZE_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or drained.
    assign en = !out_vld_reg || addr_out.ready;
    assign pix_in.ready = en;

    hwsa_mac #(.COORD_BITS(COORD_BITS)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (pix_in.valid),
        .col    (pix_in.out_col),
        .row    (pix_in.out_row),
        .m00    (m00_m01_reg[2*COEF_BITS-1:COEF_BITS]),
        .m01    (m00_m01_reg[COEF_BITS-1:0]),
        .m02    (m02_m10_reg[2*COEF_BITS-1:COEF_BITS]),
        .m10    (m02_m10_reg[COEF_BITS-1:0]),
        .m11    (m11_m12_reg[2*COEF_BITS-1:COEF_BITS]),
        .m12    (m11_m12_reg[COEF_BITS-1:0]),
        .m20    (m20_m21_reg[2*COEF_BITS-1:COEF_BITS]),
        .m21    (m20_m21_reg[COEF_BITS-1:0]),
        .m22    (m22_reg),
        .ctl    (ctl[0]),
        .abs_x  (rx[0]),
        .abs_y  (ry[0]),
        .abs_w  (dn[0])
    );

    assign qx[0] = '0;
    assign qy[0] = '0;

    // Divider chain, most significant quotient bit first.
    for (genvar j = 0; j < COORD_BITS; j++)
    begin : g_cell
        hwsa_div_cell #(.COORD_BITS(COORD_BITS), .BIT(COORD_BITS - 1 - j)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_i   (ctl[j]),
            .rem_x_i (rx[j]),
            .rem_y_i (ry[j]),
            .den_i   (dn[j]),
            .q_x_i   (qx[j]),
            .q_y_i   (qy[j]),
            .ctl_o   (ctl[j+1]),
            .rem_x_o (rx[j+1]),
            .rem_y_o (ry[j+1]),
            .den_o   (dn[j+1]),
            .q_x_o   (qx[j+1]),
            .q_y_o   (qy[j+1])
        );
    end

    // Ceil is the quotient plus one when a remainder is left; it must fit the image.
    assign ceil_x = (COORD_BITS+1)'(qx[COORD_BITS]) + (COORD_BITS+1)'(rx[COORD_BITS] != '0);
    assign ceil_y = (COORD_BITS+1)'(qy[COORD_BITS]) + (COORD_BITS+1)'(ry[COORD_BITS] != '0);
    assign fit_next = ctl[COORD_BITS].ok
                      && !ceil_x[COORD_BITS] && !ceil_y[COORD_BITS]
                      && (CMPW'(ceil_x) < CMPW'(width_reg))
                      && (CMPW'(ceil_y) < CMPW'(height_reg));

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= ctl[COORD_BITS].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg <= fit_next;
            col_reg <= fit_next ? ceil_x[COORD_BITS-1:0] : '0;
            row_reg <= fit_next ? ceil_y[COORD_BITS-1:0] : '0;
        end
    end

    assign addr_out.valid = out_vld_reg;
    assign addr_out.src_col = col_reg;
    assign addr_out.src_row = row_reg;
    assign addr_out.src_valid = sv_reg;

endmodule : homography_warp_source_address_top

`default_nettype wire

>>> src/hwsa_checker.sv
// Port-level checker for the homography warp source address block.
// Depends on hwsa_pkg; bound to the top level at the end of this file.
`default_nettype none

module hwsa_checker
    import hwsa_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [COORD_BITS-1:0] src_col,
    input wire logic [COORD_BITS-1:0] src_row,
    input wire logic                  src_valid
);

    // The input side stalls exactly when a result word is held back.
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track the output stall");

    // An invalid address is reported as zero coordinates.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !src_valid) |-> (src_col == '0 && src_row == '0))
        else $error("invalid word carries nonzero coordinates");

    // A stalled result word stays up.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(src_col) && $stable(src_row)
                                      && $stable(src_valid)))
        else $error("result payload changed while stalled");

endmodule : hwsa_checker

bind homography_warp_source_address_top hwsa_checker #(.COORD_BITS(COORD_BITS)) u_hwsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pix_in.ready),
    .out_valid (addr_out.valid),
    .out_ready (addr_out.ready),
    .src_col   (addr_out.src_col),
    .src_row   (addr_out.src_row),
    .src_valid (addr_out.src_valid)
);

`default_nettype wire
